// File: sv/airb_pkg.sv
`default_nettype none

package airb_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_TICK   = 2'd2,
    OP_ASSERT = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } state_e;

  // Write addresses of the set/clear registers.
  localparam logic [8:0] ADDR_DMACON_W = 9'h096;
  localparam logic [8:0] ADDR_INTENA_W = 9'h09A;
  localparam logic [8:0] ADDR_INTREQ_W = 9'h09C;
  localparam logic [8:0] ADDR_ADKCON_W = 9'h09E;

  // Audio channel window and register selects within a channel.
  localparam logic [8:0] ADDR_AUD_LO   = 9'h0A0;
  localparam logic [8:0] ADDR_AUD_HI   = 9'h0DA;
  localparam logic [3:0] AUD_SEL_PER   = 4'h6;
  localparam logic [3:0] AUD_SEL_VOL   = 4'h8;
  localparam logic [3:0] AUD_SEL_DAT   = 4'hA;
  localparam logic [3:0] AUD_BASE_HI   = 4'hA;

  // Read addresses.
  localparam logic [8:0] ADDR_DMACON_R = 9'h002;
  localparam logic [8:0] ADDR_ADKCON_R = 9'h010;
  localparam logic [8:0] ADDR_SERDAT_R = 9'h018;
  localparam logic [8:0] ADDR_INTENA_R = 9'h01C;
  localparam logic [8:0] ADDR_INTREQ_R = 9'h01E;

  localparam logic [15:0] SERIAL_STATUS = 16'h7FFD;
  localparam logic [15:0] VOL_MAX       = 16'd64;

  // Interrupt enable and request bit groups.
  localparam logic [14:0] INT_MASTER = 15'h4000;
  localparam logic [14:0] INT_SRC    = 15'h3FFF;
  localparam logic [14:0] GRP_L1     = 15'h0007;
  localparam logic [14:0] GRP_L2     = 15'h0008;
  localparam logic [14:0] GRP_L3     = 15'h0070;
  localparam logic [14:0] GRP_L4     = 15'h0780;
  localparam logic [14:0] GRP_L5     = 15'h1800;
  localparam logic [14:0] GRP_L6     = 15'h2000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // item taken this cycle, execute it
    logic step;    // advance every armed channel by one clock
    logic emit;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_run;   // item at the input is a tick run with a nonzero count
    logic last_tick;  // one tick remains in the current run
    logic out_free;   // result register can take a new result
  } status_t;

  // Set/clear write: bit 15 chooses set or clear of bits 14..0.
  function automatic logic [14:0] set_clr(input logic [14:0] r, input logic [15:0] v);
    if (v[15]) begin
      return r | v[14:0];
    end else begin
      return r & ~v[14:0];
    end
  endfunction

  // Priority encoder over the enabled and requested sources.
  function automatic logic [2:0] encode_level(input logic [14:0] ena, input logic [14:0] req);
    logic [14:0] act;
    logic [2:0]  lvl;
    act = (ena & INT_MASTER) != '0 ? (ena & req & INT_SRC) : '0;
    lvl = 3'd0;
    if ((act & GRP_L1) != '0) lvl = 3'd1;
    if ((act & GRP_L2) != '0) lvl = 3'd2;
    if ((act & GRP_L3) != '0) lvl = 3'd3;
    if ((act & GRP_L4) != '0) lvl = 3'd4;
    if ((act & GRP_L5) != '0) lvl = 3'd5;
    if ((act & GRP_L6) != '0) lvl = 3'd6;
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: sv/airb_in_if.sv
`default_nettype none

// Input channel: one bus access, tick run or interrupt assertion per item.
interface airb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [8:0]  bus_offset;
  logic [15:0] bus_data;
  logic [15:0] tick_count;

  modport source (output valid, operation, bus_offset, bus_data, tick_count, input ready);
  modport sink   (input valid, operation, bus_offset, bus_data, tick_count, output ready);
endinterface

`default_nettype wire

// File: sv/airb_out_if.sv
`default_nettype none

// Output channel: one result item per input item.
interface airb_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       read_data;
  logic signed [8:0] left_mix;
  logic signed [8:0] right_mix;
  logic [2:0]        irq_level;

  modport source (output valid, read_data, left_mix, right_mix, irq_level, input ready);
  modport sink   (input valid, read_data, left_mix, right_mix, irq_level, output ready);
endinterface

`default_nettype wire

// File: sv/audio_interrupt_register_block_unit.sv
// Channel   Dir  Payload                                    Handshake
// req_i     in   operation, bus_offset, bus_data, tick_count valid/ready
// rsp_o     out  read_data, left_mix, right_mix, irq_level   valid/ready
//
// A write, read or interrupt assertion, or a tick run with a count of zero, is executed
// and its result registered when it is taken; a tick run with a nonzero count then steps every armed
// channel at once, one countdown step per cycle while the final tick is not held back.
// Reset clears all registers; no clearing pass is needed.
// A new item is taken while a result waits, as long as that result is taken in the
// same cycle; a stalled output holds the final tick of a run.
`default_nettype none

module audio_interrupt_register_block_unit
  import airb_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  airb_in_if.sink    req_i,
  airb_out_if.source rsp_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  airb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  airb_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operation_i  (req_i.operation),
    .bus_offset_i (req_i.bus_offset),
    .bus_data_i   (req_i.bus_data),
    .tick_count_i (req_i.tick_count),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .read_data_o  (rsp_o.read_data),
    .left_mix_o   (rsp_o.left_mix),
    .right_mix_o  (rsp_o.right_mix),
    .irq_level_o  (rsp_o.irq_level)
  );

  assign req_i.ready = in_ready;

endmodule

`default_nettype wire

// File: sv/airb_ctrl.sv
`default_nettype none

module airb_ctrl
  import airb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        // An item is taken whenever the result register has room for its result.
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (status_i.tick_run) begin
            state_d = ST_TICK;
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      ST_TICK: begin
        // The final tick waits until its result can be stored.
        if (!status_i.last_tick) begin
          cmd_o.step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/airb_dp.sv
`default_nettype none

module airb_dp
  import airb_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  operation_i,
  input  wire logic [8:0]  bus_offset_i,
  input  wire logic [15:0] bus_data_i,
  input  wire logic [15:0] tick_count_i,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      read_data_o,
  output logic signed [8:0] left_mix_o,
  output logic signed [8:0] right_mix_o,
  output logic [2:0]       irq_level_o
);

  op_e op;
  assign op = op_e'(operation_i);

  // Control and interrupt registers.
  logic [14:0] dma_q, dma_d, ena_q, ena_d, req_q, req_d, adk_q, adk_d;
  logic [15:0] remain_q, remain_d;

  // Per-channel state.
  logic [15:0]       per_q [CHANNELS];
  logic [15:0]       per_d [CHANNELS];
  logic [6:0]        vol_q [CHANNELS];
  logic [6:0]        vol_d [CHANNELS];
  logic signed [7:0] smp_q [CHANNELS];
  logic signed [7:0] smp_d [CHANNELS];
  logic [15:0]       cnt_q [CHANNELS];
  logic [15:0]       cnt_d [CHANNELS];
  logic signed [7:0] out_q [CHANNELS];
  logic signed [7:0] out_d [CHANNELS];

  // Result register.
  logic              valid_q, valid_d;
  logic [15:0]       rdata_q, rdata_d;
  logic signed [8:0] left_q, left_d, right_q, right_d;
  logic [2:0]        lvl_q, lvl_d;

  logic        aud_hit;
  logic [1:0]  ch_sel;
  logic [3:0]  ch_hi;
  logic [15:0] rd_mux;
  logic [6:0]  vol_clamped;

  // sample * volume / 64, rounded toward zero.
  function automatic logic signed [7:0] scale(input logic signed [7:0] s,
                                              input logic [6:0] v);
    logic signed [15:0] prod;
    logic signed [15:0] quo;
    prod = s * $signed({1'b0, v});
    quo  = prod[15] ? ((prod + 16'sd63) >>> 6) : (prod >>> 6);
    return quo[7:0];
  endfunction

  // Channel address decode.
  assign aud_hit     = (op == OP_WRITE) && (bus_offset_i >= ADDR_AUD_LO) &&
                       (bus_offset_i <= ADDR_AUD_HI);
  assign ch_hi       = bus_offset_i[7:4] - AUD_BASE_HI;
  assign ch_sel      = ch_hi[1:0];
  assign vol_clamped = (bus_data_i > VOL_MAX) ? VOL_MAX[6:0] : bus_data_i[6:0];

  // Register writes, interrupt assertions and the tick run counter.
  always_comb begin
    dma_d    = dma_q;
    ena_d    = ena_q;
    req_d    = req_q;
    adk_d    = adk_q;
    remain_d = remain_q;
    if (cmd_i.accept) begin
      unique case (op)
        OP_WRITE: begin
          unique case (bus_offset_i)
            ADDR_DMACON_W: dma_d = set_clr(dma_q, bus_data_i);
            ADDR_INTENA_W: ena_d = set_clr(ena_q, bus_data_i);
            ADDR_INTREQ_W: req_d = set_clr(req_q, bus_data_i);
            ADDR_ADKCON_W: adk_d = set_clr(adk_q, bus_data_i);
            default: ;
          endcase
        end
        OP_ASSERT: req_d    = req_q | bus_data_i[14:0];
        OP_TICK:   remain_d = tick_count_i;
        OP_READ:   ;
        default:   ;
      endcase
    end else if (cmd_i.step) begin
      remain_d = remain_q - 16'd1;
    end
  end

  // Channel writes and countdown.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      per_d[i] = per_q[i];
      vol_d[i] = vol_q[i];
      smp_d[i] = smp_q[i];
      cnt_d[i] = cnt_q[i];
      out_d[i] = out_q[i];
      if (cmd_i.accept && aud_hit && ch_sel == 2'(i)) begin
        unique case (bus_offset_i[3:0])
          AUD_SEL_PER: per_d[i] = bus_data_i;
          AUD_SEL_VOL: vol_d[i] = vol_clamped;
          AUD_SEL_DAT: begin
            smp_d[i] = bus_data_i[15:8];
            cnt_d[i] = per_q[i];
          end
          default: ;
        endcase
      end else if (cmd_i.step && per_q[i] != '0 && cnt_q[i] != '0) begin
        if (cnt_q[i] == 16'd1) begin
          out_d[i] = scale(smp_q[i], vol_q[i]);
          cnt_d[i] = per_q[i];
        end else begin
          cnt_d[i] = cnt_q[i] - 16'd1;
        end
      end
    end
  end

  // Channel outputs widened to four, absent channels read as zero.
  logic signed [7:0] mix_src [4];
  for (genvar g = 0; g < 4; g++) begin : g_mix_src
    if (g < CHANNELS) begin : g_present
      assign mix_src[g] = out_d[g];
    end else begin : g_absent
      assign mix_src[g] = '0;
    end
  end

  // Read mux.
  always_comb begin
    unique case (bus_offset_i)
      ADDR_DMACON_R: rd_mux = {1'b0, dma_q};
      ADDR_ADKCON_R: rd_mux = {1'b0, adk_q};
      ADDR_SERDAT_R: rd_mux = SERIAL_STATUS;
      ADDR_INTENA_R: rd_mux = {1'b0, ena_q};
      ADDR_INTREQ_R: rd_mux = {1'b0, req_q};
      default:       rd_mux = '0;
    endcase
  end

  // Result register: loaded from the state after the item.
  always_comb begin
    valid_d = valid_q;
    rdata_d = rdata_q;
    left_d  = left_q;
    right_d = right_q;
    lvl_d   = lvl_q;
    if (cmd_i.emit) begin
      valid_d = 1'b1;
      rdata_d = (cmd_i.accept && op == OP_READ) ? rd_mux : '0;
      left_d  = 9'(mix_src[0]) + 9'(mix_src[3]);
      right_d = 9'(mix_src[1]) + 9'(mix_src[2]);
      lvl_d   = encode_level(ena_d, req_d);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_q    <= '0;
      ena_q    <= '0;
      req_q    <= '0;
      adk_q    <= '0;
      remain_q <= '0;
      valid_q  <= 1'b0;
      rdata_q  <= '0;
      left_q   <= '0;
      right_q  <= '0;
      lvl_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        per_q[i] <= '0;
        vol_q[i] <= '0;
        smp_q[i] <= '0;
        cnt_q[i] <= '0;
        out_q[i] <= '0;
      end
    end else begin
      dma_q    <= dma_d;
      ena_q    <= ena_d;
      req_q    <= req_d;
      adk_q    <= adk_d;
      remain_q <= remain_d;
      valid_q  <= valid_d;
      rdata_q  <= rdata_d;
      left_q   <= left_d;
      right_q  <= right_d;
      lvl_q    <= lvl_d;
      for (int i = 0; i < CHANNELS; i++) begin
        per_q[i] <= per_d[i];
        vol_q[i] <= vol_d[i];
        smp_q[i] <= smp_d[i];
        cnt_q[i] <= cnt_d[i];
        out_q[i] <= out_d[i];
      end
    end
  end

  // Status to the controller.
  assign status_o.tick_run  = (op == OP_TICK) && (tick_count_i != '0);
  assign status_o.last_tick = (remain_q == 16'd1);
  assign status_o.out_free  = !valid_q || out_ready_i;

  assign out_valid_o = valid_q;
  assign read_data_o = rdata_q;
  assign left_mix_o  = left_q;
  assign right_mix_o = right_q;
  assign irq_level_o = lvl_q;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb
  import airb_pkg::*;
();

  localparam int CLK_HALF    = 10;
  localparam int RESET_TICKS = 9;
  localparam int IDLE_LIMIT  = 300000;
  localparam int DRAIN_TICKS = 10;
  localparam int ITEM_GOAL   = 720;

  // Expected result of one item.
  typedef struct packed {
    logic [15:0] rd;
    logic [8:0]  lm;
    logic [8:0]  rm;
    logic [2:0]  lvl;
  } rsp_t;

  // Register file and mixer predictor with the queue of results still due.
  class register_scoreboard;
    logic [14:0] dma_q, ena_q, req_q, adk_q;
    logic [15:0] period_q[4];
    logic [15:0] cnt_q[4];
    int          vol_q[4];
    int          smp_q[4];
    int          out_q[4];
    logic [2:0]  lvl_q;
    rsp_t        due_rsp[$];
    int          errors;

    function new();
      dma_q  = '0;
      ena_q  = '0;
      req_q  = '0;
      adk_q  = '0;
      lvl_q  = '0;
      errors = 0;
      for (int c = 0; c < 4; c++) begin
        period_q[c] = '0;
        cnt_q[c]    = '0;
        vol_q[c]    = 0;
        smp_q[c]    = 0;
        out_q[c]    = 0;
      end
    endfunction

    // Bit 15 of the written word picks set or clear of the bits below it.
    function logic [14:0] set_clear(logic [14:0] cur, logic [15:0] v);
      return v[15] ? (cur | v[14:0]) : (cur & ~v[14:0]);
    endfunction

    // Highest group among the enabled and requested sources, gated by the master enable.
    function logic [2:0] level_of();
      logic [14:0] live;
      logic [2:0]  lv;
      live = ena_q[14] ? (ena_q & req_q & INT_SRC) : '0;
      lv = 3'd0;
      if ((live & GRP_L1) != '0) lv = 3'd1;
      if ((live & GRP_L2) != '0) lv = 3'd2;
      if ((live & GRP_L3) != '0) lv = 3'd3;
      if ((live & GRP_L4) != '0) lv = 3'd4;
      if ((live & GRP_L5) != '0) lv = 3'd5;
      if ((live & GRP_L6) != '0) lv = 3'd6;
      return lv;
    endfunction

    // Apply one accepted item to the state and queue the result it causes.
    function void take_item(op_e op, logic [8:0] off, logic [15:0] data, logic [15:0] ticks);
      rsp_t        r;
      logic [8:0]  rel;
      int          ch;
      int          lsum;
      int          rsum;
      r.rd = '0;
      case (op)
        OP_WRITE: begin
          rel = off - ADDR_AUD_LO;
          ch  = int'(rel[5:4]);
          case (off)
            ADDR_DMACON_W: dma_q = set_clear(dma_q, data);
            ADDR_INTENA_W: begin
              ena_q = set_clear(ena_q, data);
              lvl_q = level_of();
            end
            ADDR_INTREQ_W: begin
              req_q = set_clear(req_q, data);
              lvl_q = level_of();
            end
            ADDR_ADKCON_W: adk_q = set_clear(adk_q, data);
            default: begin
              if (off >= ADDR_AUD_LO && off <= ADDR_AUD_HI) begin
                case (rel[3:0])
                  AUD_SEL_PER: period_q[ch] = data;
                  AUD_SEL_VOL: vol_q[ch] = (data > VOL_MAX) ? int'(VOL_MAX) : int'(data);
                  AUD_SEL_DAT: begin
                    smp_q[ch] = $signed(data[15:8]);
                    cnt_q[ch] = period_q[ch];
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
        OP_READ: begin
          case (off)
            ADDR_DMACON_R: r.rd = {1'b0, dma_q};
            ADDR_ADKCON_R: r.rd = {1'b0, adk_q};
            ADDR_SERDAT_R: r.rd = SERIAL_STATUS;
            ADDR_INTENA_R: r.rd = {1'b0, ena_q};
            ADDR_INTREQ_R: r.rd = {1'b0, req_q};
            default:       r.rd = '0;
          endcase
        end
        OP_TICK: begin
          // Each clock, every armed channel counts down; at zero it plays and reloads.
          for (int k = 0; k < int'(ticks); k++) begin
            for (int c = 0; c < 4; c++) begin
              if (period_q[c] != '0 && cnt_q[c] != '0) begin
                cnt_q[c] = cnt_q[c] - 16'd1;
                if (cnt_q[c] == '0) begin
                  out_q[c] = (smp_q[c] * vol_q[c]) / 64;
                  cnt_q[c] = period_q[c];
                end
              end
            end
          end
        end
        default: begin
          req_q = req_q | data[14:0];
          lvl_q = level_of();
        end
      endcase
      lsum  = out_q[0] + out_q[3];
      rsum  = out_q[1] + out_q[2];
      r.lm  = lsum[8:0];
      r.rm  = rsum[8:0];
      r.lvl = lvl_q;
      due_rsp.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest one due.
    function void check_result(logic [15:0] rd, logic [8:0] lm, logic [8:0] rm,
                               logic [2:0] lvl);
      rsp_t want;
      if (due_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual read_data %0h", $time, rd);
        return;
      end
      want = due_rsp.pop_front();
      compare("read_data", want.rd, rd);
      compare("left_mix", 16'(want.lm), 16'(lm));
      compare("right_mix", 16'(want.rm), 16'(rm));
      compare("irq_level", 16'(want.lvl), 16'(lvl));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  airb_in_if  req_if ();
  airb_out_if rsp_if ();

  audio_interrupt_register_block_unit #(
    .CHANNELS(4)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  register_scoreboard sb = new();

  int sent = 0;
  int idle_cycles = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  // Wait before an item; calm stretches and many draws give no wait at all.
  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Mostly short tick runs, with the odd one across the full count range.
  function automatic logic [15:0] pick_ticks();
    if ($urandom_range(0, 99) == 0) return 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) return 16'd0;
    return 16'($urandom_range(1, 200));
  endfunction

  function automatic logic [8:0] aud_addr(int ch, logic [3:0] sel);
    return ADDR_AUD_LO + 9'(ch * 16) + 9'(sel);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(op_e op, logic [8:0] off, logic [15:0] data, logic [15:0] ticks);
    int gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.bus_offset <= off;
    req_if.bus_data   <= data;
    req_if.tick_count <= ticks;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.take_item(op, off, data, ticks);
    sent++;
  endtask

  task automatic bus_write(logic [8:0] off, logic [15:0] data);
    send_item(OP_WRITE, off, data, 16'($urandom));
  endtask

  task automatic bus_read(logic [8:0] off);
    send_item(OP_READ, off, 16'($urandom), 16'($urandom));
  endtask

  task automatic run_ticks(logic [15:0] n);
    send_item(OP_TICK, 9'($urandom_range(0, 511)), 16'($urandom), n);
  endtask

  task automatic raise_irq(logic [15:0] bits);
    send_item(OP_ASSERT, 9'($urandom_range(0, 511)), bits, 16'($urandom));
  endtask

  // Program one channel with a random period, volume and sample, then let it play.
  task automatic play_channel();
    int          ch;
    logic [15:0] per;
    logic [15:0] vol;
    ch  = $urandom_range(0, 3);
    per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
    case ($urandom_range(0, 3))
      0:       vol = 16'($urandom);
      1:       vol = VOL_MAX;
      default: vol = 16'($urandom_range(0, 70));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      bus_write(aud_addr(ch, 4'(2 * $urandom_range(0, 2))), 16'($urandom));
    end
    bus_write(aud_addr(ch, AUD_SEL_PER), per);
    bus_write(aud_addr(ch, AUD_SEL_VOL), vol);
    bus_write(aud_addr(ch, AUD_SEL_DAT), 16'($urandom));
    repeat ($urandom_range(1, 3)) run_ticks(pick_ticks());
  endtask

  // Exercise the interrupt enable, request and priority path.
  task automatic stir_irqs();
    logic [15:0] ena;
    ena = 16'($urandom);
    if ($urandom_range(0, 3) != 0) ena = ena | 16'hC000;
    bus_write(ADDR_INTENA_W, ena);
    raise_irq(($urandom_range(0, 1) == 0) ? (16'd1 << $urandom_range(0, 15))
                                          : 16'($urandom));
    if ($urandom_range(0, 1) == 0) bus_write(ADDR_INTREQ_W, 16'($urandom));
    bus_read(($urandom_range(0, 1) == 0) ? ADDR_INTENA_R : ADDR_INTREQ_R);
  endtask

  task automatic read_any();
    case ($urandom_range(0, 6))
      0:       bus_read(ADDR_DMACON_R);
      1:       bus_read(ADDR_ADKCON_R);
      2:       bus_read(ADDR_SERDAT_R);
      3:       bus_read(ADDR_INTENA_R);
      4:       bus_read(ADDR_INTREQ_R);
      default: bus_read(9'($urandom_range(0, 511)));
    endcase
  endtask

  // Result side: take results with random stalls and check each one.
  initial begin : rsp_sink
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 40) == 0) sink_calm = ~sink_calm;
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      sb.check_result(rsp_if.read_data, rsp_if.left_mix, rsp_if.right_mix, rsp_if.irq_level);
    end
  end

  // Give up when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Stimulus: reset, directed cases, random scenes, then drain and report.
  initial begin : stimulus
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_WRITE;
    req_if.bus_offset = '0;
    req_if.bus_data   = '0;
    req_if.tick_count = '0;
    repeat (RESET_TICKS) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Serial status word and the priority encoder with and without the master enable.
    bus_read(ADDR_SERDAT_R);
    bus_write(ADDR_INTENA_W, 16'hFFFF);
    raise_irq(16'h0001);
    raise_irq(16'hA000);
    bus_write(ADDR_INTREQ_W, 16'h2000);
    bus_write(ADDR_INTENA_W, 16'h4000);
    bus_write(ADDR_DMACON_W, 16'hFFFF);
    bus_read(ADDR_DMACON_R);

    // Full-scale samples on every channel drive both mixes to their extremes.
    for (int c = 0; c < 4; c++) begin
      bus_write(aud_addr(c, AUD_SEL_PER), 16'(c + 1));
      bus_write(aud_addr(c, AUD_SEL_VOL), (c == 0) ? 16'hFFFF : ((c == 3) ? 16'd65 : VOL_MAX));
      bus_write(aud_addr(c, AUD_SEL_DAT), (c == 0 || c == 3) ? 16'h7FFF : 16'h8000);
    end
    run_ticks(16'd12);

    // A small negative product truncates toward zero, not down.
    bus_write(aud_addr(0, AUD_SEL_VOL), 16'd1);
    bus_write(aud_addr(0, AUD_SEL_DAT), 16'hFF00);
    run_ticks(16'd1);

    // Unknown offsets, an empty tick run and the longest one.
    bus_write(9'h1FF, 16'hFFFF);
    bus_read(9'h1FF);
    run_ticks(16'd0);
    run_ticks(16'hFFFF);

    // Random scenes, mostly well-formed channel and interrupt sequences.
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(0, 15) == 0) src_calm = ~src_calm;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: play_channel();
        4, 5:       stir_irqs();
        6:          read_any();
        7: begin
          bus_write(($urandom_range(0, 1) == 0) ? ADDR_DMACON_W : ADDR_ADKCON_W, 16'($urandom));
          read_any();
        end
        8: send_item(op_e'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                     16'($urandom), pick_ticks());
        default: run_ticks(pick_ticks());
      endcase
    end
    req_if.valid <= 1'b0;

    // Wait for every result due, then a short quiet spell for stray ones.
    while (sb.due_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
